// ----- src/hrp_pkg.sv -----
package hrp_pkg;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE  = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG    = 3'd5;

  // character constants
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int NUM_TOKENS = 9;
  localparam int OFF_W      = 13;
  localparam int CNT_OUT_W  = 6;
  localparam int TDATA_W    = 104;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_SP1,
    PH_PATH,
    PH_VER,
    PH_AFTER_MAJOR,
    PH_DOT,
    PH_MINOR_DONE,
    PH_LF1,
    PH_LINE_START,
    PH_LINE_CR,
    PH_NAME,
    PH_VALUE,
    PH_HDR_LF
  } phase_t;

  typedef struct packed {
    logic                 kind;
    logic [2:0]           status;
    logic [3:0]           method;
    logic [3:0]           version_major;
    logic [3:0]           version_minor;
    logic [OFF_W-1:0]     path_offset;
    logic [OFF_W-1:0]     path_length;
    logic [CNT_OUT_W-1:0] header_count;
    logic [OFF_W-1:0]     name_offset;
    logic [OFF_W-1:0]     name_length;
    logic [OFF_W-1:0]     value_offset;
    logic [OFF_W-1:0]     value_length;
  } rec_t;

  // records produced by one byte, header record first
  typedef struct packed {
    logic hdr_push;
    logic fin_push;
    rec_t hdr_rec;
    rec_t fin_rec;
  } push_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] count;
    logic                room2;
  } oq_stat_t;

  function automatic logic [2:0] tok_len(input logic [3:0] t);
    logic [2:0] len;
    case (t)
      4'd0:    len = 3'd3;
      4'd1:    len = 3'd4;
      4'd2:    len = 3'd4;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd6;
      4'd5:    len = 3'd7;
      4'd6:    len = 3'd7;
      4'd7:    len = 3'd5;
      4'd8:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] tok_char(input logic [3:0] t, input logic [2:0] idx);
    logic [55:0] txt;
    case (t)
      4'd0:    txt = {"    ", "TEG"};
      4'd1:    txt = {"   ", "DAEH"};
      4'd2:    txt = {"   ", "TSOP"};
      4'd3:    txt = {"    ", "TUP"};
      4'd4:    txt = {" ", "ETELED"};
      4'd5:    txt = "TCENNOC";
      4'd6:    txt = "SNOITPO";
      4'd7:    txt = {"  ", "ECART"};
      4'd8:    txt = {"  ", "HCTAP"};
      default: txt = '0;
    endcase
    // characters stored reversed, first character in the low byte
    case (idx)
      3'd0:    return txt[7:0];
      3'd1:    return txt[15:8];
      3'd2:    return txt[23:16];
      3'd3:    return txt[31:24];
      3'd4:    return txt[39:32];
      3'd5:    return txt[47:40];
      3'd6:    return txt[55:48];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = CH_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hrp_out_fifo.sv -----
module hrp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  hrp_pkg::push_t    push,
  input  logic              pop,
  output logic              head_valid,
  output hrp_pkg::rec_t     head_rec,
  output hrp_pkg::oq_stat_t stat
);

  hrp_pkg::rec_t                   mem_r [hrp_pkg::OQ_DEPTH];
  logic [hrp_pkg::OQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hrp_pkg::OQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [hrp_pkg::OQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [hrp_pkg::OQ_PTR_W-1:0]    fin_ptr;
  logic                            do_pop;

  assign do_pop  = pop && (cnt_r != '0);
  assign fin_ptr = wr_ptr_r + hrp_pkg::OQ_PTR_W'(push.hdr_push);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + hrp_pkg::OQ_PTR_W'(push.hdr_push)
                          + hrp_pkg::OQ_PTR_W'(push.fin_push);
    rd_ptr_nxt = rd_ptr_r + hrp_pkg::OQ_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + hrp_pkg::OQ_CNT_W'(push.hdr_push)
                       + hrp_pkg::OQ_CNT_W'(push.fin_push)
                       - hrp_pkg::OQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.hdr_push) begin
      mem_r[wr_ptr_r] <= push.hdr_rec;
    end
    if (push.fin_push) begin
      mem_r[fin_ptr] <= push.fin_rec;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.room2 = (cnt_r <= hrp_pkg::OQ_CNT_W'(hrp_pkg::OQ_DEPTH - 2));

endmodule

// ----- src/hrp_parse_core.sv -----
module hrp_parse_core #(
  parameter int MAX_HEAD_BYTES = 8192,
  parameter int HEADER_LIMIT   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [7:0]     data_byte,
  input  logic           end_of_buffer,
  output hrp_pkg::push_t push
);

  localparam int POS_W = $clog2(MAX_HEAD_BYTES + 1);
  localparam int HK_W  = $clog2(HEADER_LIMIT + 1);
  localparam int OW    = hrp_pkg::OFF_W;

  hrp_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]         tok_idx_r, tok_idx_nxt;
  logic [8:0]         cand_r, cand_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [OW-1:0]      path_start_r, path_start_nxt;
  logic [OW-1:0]      path_len_r, path_len_nxt;
  logic [OW-1:0]      field_start_r, field_start_nxt;
  logic [OW-1:0]      name_len_r, name_len_nxt;
  logic [OW-1:0]      value_start_r, value_start_nxt;
  logic [OW-1:0]      value_len_r, value_len_nxt;
  logic [HK_W-1:0]    hk_r, hk_nxt;
  logic [3:0]         major_r, major_nxt;
  logic [3:0]         minor_r, minor_nxt;
  logic [3:0]         method_r, method_nxt;
  logic               fin_r, fin_nxt;

  logic [OW-1:0]      pos13;
  logic               is_dig;
  logic               hit;
  logic [3:0]         hit_idx;
  logic               st_valid;
  logic [2:0]         st_code;
  logic               end_valid;
  logic [2:0]         end_code;
  logic               hdr_emit;
  logic [2:0]         fin_status;
  logic               fin_emit;

  assign pos13  = OW'(pos_r);
  assign is_dig = (data_byte >= hrp_pkg::CH_ZERO) && (data_byte <= hrp_pkg::CH_NINE);

  // method match: candidates drop out per byte, a full match ends the token
  always_comb begin
    cand_nxt = cand_r;
    hit      = 1'b0;
    hit_idx  = '0;
    for (int t = 0; t < hrp_pkg::NUM_TOKENS; t++) begin
      if (cand_r[t]) begin
        if (tok_idx_r >= hrp_pkg::tok_len(4'(t)) ||
            hrp_pkg::tok_char(4'(t), tok_idx_r) != data_byte) begin
          cand_nxt[t] = 1'b0;
        end else if (tok_idx_r + 3'd1 == hrp_pkg::tok_len(4'(t))) begin
          hit     = 1'b1;
          hit_idx = 4'(t);
        end
      end
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    tok_idx_nxt     = tok_idx_r;
    pos_nxt         = pos_r;
    path_start_nxt  = path_start_r;
    path_len_nxt    = path_len_r;
    field_start_nxt = field_start_r;
    name_len_nxt    = name_len_r;
    value_start_nxt = value_start_r;
    value_len_nxt   = value_len_r;
    hk_nxt          = hk_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    method_nxt      = method_r;
    fin_nxt         = fin_r;
    st_valid        = 1'b0;
    st_code         = hrp_pkg::ST_OK;
    end_valid       = 1'b0;
    end_code        = hrp_pkg::ST_OK;
    hdr_emit        = 1'b0;
    fin_emit        = 1'b0;
    fin_status      = hrp_pkg::ST_OK;

    if (go && !fin_r) begin
      if (pos_r >= POS_W'(MAX_HEAD_BYTES)) begin
        fin_nxt    = 1'b1;
        fin_emit   = 1'b1;
        fin_status = hrp_pkg::ST_TOO_LONG;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        case (phase_r)
          hrp_pkg::PH_METHOD: begin
            tok_idx_nxt = tok_idx_r + 3'd1;
            if (hit) begin
              method_nxt = hit_idx;
              phase_nxt  = hrp_pkg::PH_SP1;
              end_valid  = 1'b1;
              end_code   = hrp_pkg::ST_INCOMPLETE;
            end else if (cand_nxt == '0) begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_BAD_METHOD;
            end else begin
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_BAD_METHOD;
            end
          end
          hrp_pkg::PH_SP1: begin
            if (data_byte == hrp_pkg::CH_SP) begin
              path_start_nxt = pos13 + OW'(1);
              phase_nxt      = hrp_pkg::PH_PATH;
              end_valid      = 1'b1;
              end_code       = hrp_pkg::ST_INCOMPLETE;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_INCOMPLETE;
            end
          end
          hrp_pkg::PH_PATH: begin
            end_valid = 1'b1;
            if (data_byte == hrp_pkg::CH_SP) begin
              path_len_nxt = pos13 - path_start_r;
              tok_idx_nxt  = '0;
              phase_nxt    = hrp_pkg::PH_VER;
              end_code     = hrp_pkg::ST_BAD_VERSION;
            end else begin
              end_code = hrp_pkg::ST_INCOMPLETE;
            end
          end
          hrp_pkg::PH_VER: begin
            if (tok_idx_r < 3'd5) begin
              if (hrp_pkg::ver_char(tok_idx_r) != data_byte) begin
                st_valid = 1'b1;
                st_code  = hrp_pkg::ST_BAD_VERSION;
              end else begin
                tok_idx_nxt = tok_idx_r + 3'd1;
                end_valid   = 1'b1;
                end_code    = hrp_pkg::ST_BAD_VERSION;
              end
            end else if (is_dig) begin
              major_nxt = data_byte[3:0];
              phase_nxt = hrp_pkg::PH_AFTER_MAJOR;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_INCOMPLETE;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_BAD_VERSION;
            end
          end
          hrp_pkg::PH_AFTER_MAJOR: begin
            if (data_byte == hrp_pkg::CH_DOT) begin
              phase_nxt = hrp_pkg::PH_DOT;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_BAD_VERSION;
            end else if (data_byte == hrp_pkg::CH_CR) begin
              phase_nxt = hrp_pkg::PH_LF1;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_INCOMPLETE;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_INCOMPLETE;
            end
          end
          hrp_pkg::PH_DOT: begin
            if (is_dig) begin
              minor_nxt = data_byte[3:0];
              phase_nxt = hrp_pkg::PH_MINOR_DONE;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_INCOMPLETE;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_BAD_VERSION;
            end
          end
          hrp_pkg::PH_MINOR_DONE: begin
            if (data_byte == hrp_pkg::CH_CR) begin
              phase_nxt = hrp_pkg::PH_LF1;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_INCOMPLETE;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_INCOMPLETE;
            end
          end
          hrp_pkg::PH_LF1: begin
            if (data_byte == hrp_pkg::CH_LF) begin
              phase_nxt = hrp_pkg::PH_LINE_START;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_BAD_HEADER;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_INCOMPLETE;
            end
          end
          hrp_pkg::PH_LINE_START, hrp_pkg::PH_LINE_CR, hrp_pkg::PH_NAME: begin
            end_valid = 1'b1;
            end_code  = hrp_pkg::ST_BAD_HEADER;
            if (phase_r == hrp_pkg::PH_LINE_START) begin
              field_start_nxt = pos13;
            end
            if (phase_r == hrp_pkg::PH_LINE_START && data_byte == hrp_pkg::CH_CR) begin
              phase_nxt = hrp_pkg::PH_LINE_CR;
            end else if (phase_r == hrp_pkg::PH_LINE_CR && data_byte == hrp_pkg::CH_LF) begin
              // blank line closes the head
              end_valid = 1'b0;
              st_valid  = 1'b1;
              st_code   = hrp_pkg::ST_OK;
            end else if (data_byte == hrp_pkg::CH_COLON) begin
              // field start is this byte when the line starts with the colon
              name_len_nxt    = pos13 - field_start_nxt;
              value_start_nxt = pos13 + OW'(1);
              phase_nxt       = hrp_pkg::PH_VALUE;
            end else begin
              phase_nxt = hrp_pkg::PH_NAME;
            end
          end
          hrp_pkg::PH_VALUE: begin
            end_valid = 1'b1;
            end_code  = hrp_pkg::ST_BAD_HEADER;
            if (data_byte == hrp_pkg::CH_CR) begin
              value_len_nxt = pos13 - value_start_r;
              phase_nxt     = hrp_pkg::PH_HDR_LF;
            end
          end
          hrp_pkg::PH_HDR_LF: begin
            if (data_byte == hrp_pkg::CH_LF) begin
              if (hk_r < HK_W'(HEADER_LIMIT)) begin
                hk_nxt   = hk_r + HK_W'(1);
                hdr_emit = 1'b1;
              end
              phase_nxt = hrp_pkg::PH_LINE_START;
              end_valid = 1'b1;
              end_code  = hrp_pkg::ST_BAD_HEADER;
            end else begin
              st_valid = 1'b1;
              st_code  = hrp_pkg::ST_BAD_HEADER;
            end
          end
          default: begin
            phase_nxt = hrp_pkg::PH_METHOD;
          end
        endcase

        if (st_valid) begin
          fin_emit   = 1'b1;
          fin_status = st_code;
        end else if (end_valid && end_of_buffer) begin
          fin_emit   = 1'b1;
          fin_status = end_code;
        end
        if (fin_emit) begin
          fin_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push.hdr_push              = hdr_emit;
    push.fin_push              = fin_emit;
    push.hdr_rec.kind          = 1'b0;
    push.hdr_rec.status        = hrp_pkg::ST_OK;
    push.hdr_rec.method        = method_nxt;
    push.hdr_rec.version_major = major_nxt;
    push.hdr_rec.version_minor = minor_nxt;
    push.hdr_rec.path_offset   = path_start_nxt;
    push.hdr_rec.path_length   = path_len_nxt;
    push.hdr_rec.header_count  = hrp_pkg::CNT_OUT_W'(hk_nxt);
    push.hdr_rec.name_offset   = field_start_r;
    push.hdr_rec.name_length   = name_len_r;
    push.hdr_rec.value_offset  = value_start_r;
    push.hdr_rec.value_length  = value_len_r;
    push.fin_rec               = push.hdr_rec;
    push.fin_rec.kind          = 1'b1;
    push.fin_rec.status        = fin_status;
    push.fin_rec.name_offset   = '0;
    push.fin_rec.name_length   = '0;
    push.fin_rec.value_offset  = '0;
    push.fin_rec.value_length  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hrp_pkg::PH_METHOD;
      tok_idx_r     <= '0;
      cand_r        <= '1;
      pos_r         <= '0;
      path_start_r  <= '0;
      path_len_r    <= '0;
      field_start_r <= '0;
      name_len_r    <= '0;
      value_start_r <= '0;
      value_len_r   <= '0;
      hk_r          <= '0;
      major_r       <= '0;
      minor_r       <= '0;
      method_r      <= '0;
      fin_r         <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      tok_idx_r     <= tok_idx_nxt;
      cand_r        <= (go && !fin_r && phase_r == hrp_pkg::PH_METHOD &&
                        pos_r < POS_W'(MAX_HEAD_BYTES)) ? cand_nxt : cand_r;
      pos_r         <= pos_nxt;
      path_start_r  <= path_start_nxt;
      path_len_r    <= path_len_nxt;
      field_start_r <= field_start_nxt;
      name_len_r    <= name_len_nxt;
      value_start_r <= value_start_nxt;
      value_len_r   <= value_len_nxt;
      hk_r          <= hk_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
      method_r      <= method_nxt;
      fin_r         <= fin_nxt;
    end
  end

endmodule

// ----- src/http_request_head_parser_top.sv -----
// http/1.x request head parser
// in_* channel: one request byte per beat, in_tlast marks the last byte that
// the buffer currently holds. out_* channel: one beat per result record.
// a header record (out_tlast low) is sent for each header line kept, up to
// HEADER_LIMIT; the final record (out_tlast high) carries status, method,
// version, path position and header count and closes the run. after it,
// further input beats are taken and dropped until reset.
// path: a taken byte waits in the byte register until the result queue has room
// for two more records; it is then parsed and its records enter the queue,
// which drives out_*. throughput: one byte per cycle while the queue has that
// room; each byte only steps the phase machine and its counters. a byte that
// ends a header line while the buffer also ends yields two records, which
// leave on separate output beats. stalls: parsed records wait in a four-entry
// result queue; the byte register keeps taking bytes while the queue has room
// for two more records, so a stalled receiver backs up into in_tready.
// reset: rst_n low at a clock edge empties the queue and the byte register
// and returns the parser to the method phase at byte offset zero.
// a head longer than MAX_HEAD_BYTES ends with status too_long.
module http_request_head_parser_top #(
  parameter int MAX_HEAD_BYTES = 8192,
  parameter int HEADER_LIMIT   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,  // [7:0] data_byte
  input  logic                        in_tlast,  // end_of_buffer
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] status, [6:3] method, [10:7] version_major, [14:11] version_minor,
  // [27:15] path_offset, [40:28] path_length, [46:41] header_count,
  // [59:47] name_offset, [72:60] name_length, [85:73] value_offset,
  // [98:86] value_length, [103:99] zero
  output logic [hrp_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast  // kind, high on the final record
);

  // input byte register
  logic              in_v_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              fire;

  hrp_pkg::push_t    push;
  hrp_pkg::oq_stat_t oq_stat;
  hrp_pkg::rec_t     head_rec;
  logic              head_valid;

  // parse the held byte once the queue can take both records it may yield
  assign fire      = in_v_r && oq_stat.room2;
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  hrp_parse_core #(
    .MAX_HEAD_BYTES (MAX_HEAD_BYTES),
    .HEADER_LIMIT   (HEADER_LIMIT)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (fire),
    .data_byte     (byte_r),
    .end_of_buffer (last_r),
    .push          (push)
  );

  hrp_out_fifo u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .stat       (oq_stat)
  );

  assign out_tvalid = head_valid;
  assign out_tlast  = head_rec.kind;
  assign out_tdata  = {5'b0,
                       head_rec.value_length,
                       head_rec.value_offset,
                       head_rec.name_length,
                       head_rec.name_offset,
                       head_rec.header_count,
                       head_rec.path_length,
                       head_rec.path_offset,
                       head_rec.version_minor,
                       head_rec.version_major,
                       head_rec.method,
                       head_rec.status};

  // queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_stat.count <= hrp_pkg::OQ_CNT_W'(hrp_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  // nothing follows the final record
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("record after final record");

  // header records always carry ok status
  a_hdr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[2:0] == hrp_pkg::ST_OK)
    else $error("header record with error status");

  // a parse step only runs with room for two records
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.hdr_push || push.fin_push |-> fire && oq_stat.room2)
    else $error("record pushed without a parse step");

endmodule
